// ----- rtl/tmcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, character codes, command and state encodings, and the
// cursor clamp function.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CMD_W  = 3;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
  localparam logic [CELL_W-1:0] INIT_CELL  = 16'h0F20;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 3'd0,
    CMD_SET   = 3'd1,
    CMD_MOVE  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DONE,
    ST_CLEAR,
    ST_SCROLL
  } state_t;

  typedef struct packed {
    logic write_cell;
    logic scroll;
  } cursor_info_t;

  function automatic logic [COL_W-1:0] clamp_pos(input logic signed [9:0] v,
                                                 input logic [COL_W-1:0] hi);
    logic [COL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b000, hi})) begin
      r = hi;
    end else begin
      r = v[COL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tmcw_mem.sv -----
// ----------------------------------------------------------------------------
// Text console cell memory
// Single write port, single read port, read data registered on a read.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_mem #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [tmcw_pkg::CELL_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [tmcw_pkg::CELL_W-1:0] rdata
);
  import tmcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tmcw_cursor.sv -----
// ----------------------------------------------------------------------------
// Text console cursor
// Holds the cursor and works out its next position for each command,
// including tab stops, line wrap and the scroll condition.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_cursor #(
  parameter int COLS   = 80,
  parameter int ROWS   = 25,
  parameter int ADDR_W = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       upd,
  input  logic [tmcw_pkg::CMD_W-1:0] cmd,
  input  logic [7:0]                 char_code,
  input  logic signed [7:0]          pos_x,
  input  logic signed [7:0]          pos_y,
  output logic [tmcw_pkg::COL_W-1:0] col,
  output logic [tmcw_pkg::ROW_W-1:0] row,
  output logic [ADDR_W-1:0]          cell_addr,
  output tmcw_pkg::cursor_info_t     info
);
  import tmcw_pkg::*;

  localparam logic [COL_W:0]   COL_END = (COL_W+1)'(COLS);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W:0]    col_step;
  logic              line_end;
  logic signed [9:0] ext_x;
  logic signed [9:0] ext_y;
  logic signed [9:0] sum_x;
  logic signed [9:0] sum_y;
  logic [COL_W-1:0]  row_set;
  logic [COL_W-1:0]  row_move;

  assign cell_addr = ADDR_W'(row * COLS + col);

  always_comb begin
    ext_x    = $signed({{2{pos_x[7]}}, pos_x});
    ext_y    = $signed({{2{pos_y[7]}}, pos_y});
    sum_x    = $signed({3'b000, col}) + ext_x;
    sum_y    = $signed({5'b00000, row}) + ext_y;
    row_set  = clamp_pos(ext_y, COL_W'(ROW_MAX));
    row_move = clamp_pos(sum_y, COL_W'(ROW_MAX));
    if (char_code == CH_TAB) begin
      col_step = ({1'b0, col} | (COL_W+1)'(3)) + (COL_W+1)'(1);
    end else begin
      col_step = {1'b0, col} + (COL_W+1)'(1);
    end
    line_end = (char_code == CH_NEWLINE) || (col_step >= COL_END);
  end

  always_comb begin
    col_next = col;
    row_next = row;
    info     = '0;
    unique case (cmd_t'(cmd))
      CMD_PUT: begin
        info.write_cell = (char_code != CH_TAB) && (char_code != CH_NEWLINE);
        if (line_end) begin
          col_next = '0;
          if (row == ROW_MAX) begin
            info.scroll = 1'b1;
          end else begin
            row_next = row + ROW_W'(1);
          end
        end else begin
          col_next = col_step[COL_W-1:0];
        end
      end
      CMD_SET: begin
        col_next = clamp_pos(ext_x, COL_MAX);
        row_next = row_set[ROW_W-1:0];
      end
      CMD_MOVE: begin
        col_next = clamp_pos(sum_x, COL_MAX);
        row_next = row_move[ROW_W-1:0];
      end
      default: begin
        col_next = col;
        row_next = row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (upd) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tmcw_seq.sv -----
// ----------------------------------------------------------------------------
// Text console sequencer
// Command control, memory sweeps for initialization, clear and scroll, the
// attribute register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_seq #(
  parameter int COLS   = 80,
  parameter int ROWS   = 25,
  parameter int ADDR_W = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        accept,
  input  logic [tmcw_pkg::CMD_W-1:0]  cmd,
  input  logic [7:0]                  char_code,
  input  logic [tmcw_pkg::IDX_W-1:0]  cell_index,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata,
  input  tmcw_pkg::cursor_info_t      info,
  input  logic [ADDR_W-1:0]           cell_addr,
  input  logic [tmcw_pkg::COL_W-1:0]  cur_col,
  input  logic [tmcw_pkg::ROW_W-1:0]  cur_row,
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_waddr,
  output logic [tmcw_pkg::CELL_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_raddr,
  input  logic [tmcw_pkg::CELL_W-1:0] mem_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
  output logic [tmcw_pkg::CELL_W-1:0] read_data,
  output logic                        did_scroll
);
  import tmcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam logic [CNT_W-1:0] LAST_CELL  = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0] SCROLL_END = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] NCOPY      = CNT_W'(COLS * (ROWS - 1));

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       attr;
  logic             res_read;
  logic             res_scroll;
  logic             load_out;
  logic             in_range;
  logic             is_read;

  assign in_range = 32'(cell_index) < 32'(CELLS);
  assign is_read  = (cmd_t'(cmd) == CMD_READ) && in_range;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (cnt == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd_t'(cmd) == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (info.scroll) begin
            state_next = ST_SCROLL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        if (cnt == LAST_CELL) begin
          state_next = ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (cnt == SCROLL_END) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    accept    = in_valid && (state == ST_IDLE);
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt[ADDR_W-1:0];
    mem_wdata = INIT_CELL;
    mem_re    = 1'b0;
    mem_raddr = ADDR_W'(cell_index);
    unique case (state)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we    = accept && info.write_cell;
        mem_waddr = cell_addr;
        mem_wdata = {attr, char_code};
        mem_re    = accept && is_read;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {attr, CH_SPACE};
      end
      ST_SCROLL: begin
        mem_we    = (cnt != '0);
        mem_waddr = ADDR_W'(cnt - CNT_W'(1));
        mem_wdata = (cnt <= NCOPY) ? mem_rdata : BLANK_CELL;
        mem_re    = (cnt < NCOPY);
        mem_raddr = ADDR_W'(cnt + COLS);
      end
      ST_DONE: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      attr       <= ATTR_RESET;
      res_read   <= 1'b0;
      res_scroll <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_INIT || state == ST_CLEAR || state == ST_SCROLL) &&
          state_next == state) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      if (accept) begin
        res_read   <= is_read;
        res_scroll <= info.scroll;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cursor_col <= cur_col;
      cursor_row <= cur_row;
      read_data  <= res_read ? mem_rdata : '0;
      did_scroll <= res_scroll;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/text_mode_console_writer.sv -----
// Flow: an accepted put, set position, move position or read goes to the DONE
// state, which loads its result into the output registers once they are free;
// scroll and clear first run a one-cell-per-cycle memory sweep in SCROLL or CLEAR.
// Commands: in_ready stays low from an accepted command until its result is loaded.
// Reset: rst is synchronous; afterwards a pass over all COLS*ROWS cells writes
// each of them to 0x0F20 while in_ready stays low.
// ----------------------------------------------------------------------------
// Text mode console writer
// A character cell store with a cursor: put character, set and move position,
// read cell and clear, with line wrap and scroll on the last row.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tmcw_pkg::CMD_W-1:0]  cmd,
  input  logic [7:0]                  char_code,
  input  logic signed [7:0]           pos_x,
  input  logic signed [7:0]           pos_y,
  input  logic [tmcw_pkg::IDX_W-1:0]  cell_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
  output logic [tmcw_pkg::CELL_W-1:0] read_data,
  output logic                        did_scroll,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata
);
  import tmcw_pkg::*;

  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic              accept;
  cursor_info_t      info;
  logic [ADDR_W-1:0] cell_addr;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tmcw_cursor #(
    .COLS   (COLS),
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .upd       (accept),
    .cmd       (cmd),
    .char_code (char_code),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .col       (cur_col),
    .row       (cur_row),
    .cell_addr (cell_addr),
    .info      (info)
  );

  tmcw_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tmcw_seq #(
    .COLS   (COLS),
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .accept     (accept),
    .cmd        (cmd),
    .char_code  (char_code),
    .cell_index (cell_index),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .info       (info),
    .cell_addr  (cell_addr),
    .cur_col    (cur_col),
    .cur_row    (cur_row),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .read_data  (read_data),
    .did_scroll (did_scroll)
  );

endmodule

`default_nettype wire

// ----- rtl/tmcw_checker.sv -----
// ----------------------------------------------------------------------------
// Text console port checker
// Checks result holding, the reset pass, command spacing, cursor sanity and the
// scroll position as seen on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tmcw_pkg::COL_W-1:0]  cursor_col,
  input logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
  input logic [tmcw_pkg::CELL_W-1:0] read_data,
  input logic                        did_scroll
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_col) &&
      $stable(cursor_row) && $stable(read_data) && $stable(did_scroll))
    else $error("Result changed while its transfer was stalled.");

  a_reset_pass: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("Block ready or holding a result right after reset.");

  a_item_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("A second command was taken in the cycle after a transfer.");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_col) < 32'(COLS)) && (32'(cursor_row) < 32'(ROWS)))
    else $error("Reported cursor lies outside the screen.");

  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && did_scroll |-> (cursor_col == '0) &&
      (32'(cursor_row) == 32'(ROWS - 1)))
    else $error("Scroll reported without the cursor at the start of the last row.");

endmodule

bind text_mode_console_writer tmcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tmcw_checker (.*);

`default_nettype wire

// ----- bench/text_mode_console_writer_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode console writer checker
// Watches the command, result and attribute ports of the console writer. It
// keeps its own screen, cursor and attribute, works out the expected result of
// every accepted command, and compares each result transfer field by field
// with the oldest report still owed.
// ----------------------------------------------------------------------------
module text_mode_console_writer_check #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [tmcw_pkg::CMD_W-1:0]  cmd,
  input  logic [7:0]                  char_code,
  input  logic signed [7:0]           pos_x,
  input  logic signed [7:0]           pos_y,
  input  logic [tmcw_pkg::IDX_W-1:0]  cell_index,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [tmcw_pkg::COL_W-1:0]  cursor_col,
  input  logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
  input  logic [tmcw_pkg::CELL_W-1:0] read_data,
  input  logic                        did_scroll,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata,
  output int                          status_owed,
  output int                          errors
);
  import tmcw_pkg::*;

  localparam int CELLS    = COLS * ROWS;
  localparam int TAB_STOP = 4;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] data;
    logic              scroll;
  } console_status_t;

  logic [CELL_W-1:0] screen [CELLS];
  int                col_now;
  int                row_now;
  logic [7:0]        attr;
  console_status_t   awaited_status [$];

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic int clip(input int v, input int hi);
    int r;
    r = v;
    if (r < 0) begin
      r = 0;
    end else if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // Moves the cursor to the start of the next line, scrolling on the last row.
  function automatic bit next_line();
    bit rolled;
    rolled  = 1'b0;
    col_now = 0;
    if (row_now >= ROWS - 1) begin
      for (int i = 0; i < CELLS - COLS; i++) begin
        screen[i] = screen[i + COLS];
      end
      for (int i = CELLS - COLS; i < CELLS; i++) begin
        screen[i] = BLANK_CELL;
      end
      row_now = ROWS - 1;
      rolled  = 1'b1;
    end else begin
      row_now++;
    end
    return rolled;
  endfunction

  function automatic console_status_t apply_command(input logic [CMD_W-1:0] c,
                                                    input logic [7:0] ch,
                                                    input logic signed [7:0] x,
                                                    input logic signed [7:0] y,
                                                    input logic [IDX_W-1:0] idx);
    console_status_t r;
    r = '0;
    case (c)
      CMD_PUT: begin
        if (ch == CH_TAB) begin
          col_now += TAB_STOP - col_now % TAB_STOP;
        end else if (ch == CH_NEWLINE) begin
          r.scroll = next_line();
        end else begin
          screen[row_now * COLS + col_now] = {attr, ch};
          col_now++;
        end
        if (col_now >= COLS) begin
          if (next_line()) begin
            r.scroll = 1'b1;
          end
        end
      end
      CMD_SET: begin
        col_now = clip(int'(x), COLS - 1);
        row_now = clip(int'(y), ROWS - 1);
      end
      CMD_MOVE: begin
        col_now = clip(col_now + int'(x), COLS - 1);
        row_now = clip(row_now + int'(y), ROWS - 1);
      end
      CMD_READ: begin
        if (idx < CELLS) begin
          r.data = screen[idx];
        end
      end
      CMD_CLEAR: begin
        foreach (screen[i]) begin
          screen[i] = {attr, CH_SPACE};
        end
      end
      default: begin
      end
    endcase
    r.col = col_now[COL_W-1:0];
    r.row = row_now[ROW_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    console_status_t want;
    if (rst) begin
      foreach (screen[i]) begin
        screen[i] = INIT_CELL;
      end
      col_now = 0;
      row_now = 0;
      attr    = ATTR_RESET;
      errors  = 0;
      awaited_status.delete();
      status_owed <= 0;
    end else begin
      if (cfg_we) begin
        attr = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (awaited_status.size() == 0) begin
          report_mismatch("result transfer with no command outstanding");
        end else begin
          want = awaited_status.pop_front();
          if (cursor_col !== want.col) begin
            report_mismatch($sformatf("cursor_col %0d, expected %0d", cursor_col, want.col));
          end
          if (cursor_row !== want.row) begin
            report_mismatch($sformatf("cursor_row %0d, expected %0d", cursor_row, want.row));
          end
          if (read_data !== want.data) begin
            report_mismatch($sformatf("read_data %h, expected %h", read_data, want.data));
          end
          if (did_scroll !== want.scroll) begin
            report_mismatch($sformatf("did_scroll %b, expected %b", did_scroll, want.scroll));
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_status.push_back(apply_command(cmd, char_code, pos_x, pos_y, cell_index));
      end
      status_owed <= awaited_status.size();
    end
  end

endmodule

// ----- bench/text_mode_console_writer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode console writer testbench
// Drives directed commands at the screen and cursor limits, then random text
// bursts mixed with cursor moves, reads, clears and spare codes, under three
// patterns of idle cycles on both sides and several attribute settings.
// ----------------------------------------------------------------------------
module text_mode_console_writer_test;
  import tmcw_pkg::*;

  localparam int COLS          = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = COLS * ROWS;
  localparam int CMD_CODES     = 1 << CMD_W;
  localparam int PHASE_ITEMS   = 545;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 20_000_000;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(CMD_CLEAR + 1);
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = CMD_W'(CMD_CODES - 1);

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd        = '0;
  logic [7:0]        char_code  = '0;
  logic signed [7:0] pos_x      = '0;
  logic signed [7:0] pos_y      = '0;
  logic [IDX_W-1:0]  cell_index = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CELL_W-1:0] read_data;
  logic              did_scroll;
  logic              cfg_we     = 1'b0;
  logic [7:0]        cfg_wdata  = '0;

  int status_owed;
  int errors;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ticket   = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int items_done    = 0;
  int cycles        = 0;

  text_mode_console_writer #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .char_code  (char_code),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .read_data  (read_data),
    .did_scroll (did_scroll),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  text_mode_console_writer_check #(.COLS(COLS), .ROWS(ROWS)) watcher (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .char_code   (char_code),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .cell_index  (cell_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cursor_col  (cursor_col),
    .cursor_row  (cursor_row),
    .read_data   (read_data),
    .did_scroll  (did_scroll),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .status_owed (status_owed),
    .errors      (errors)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("text_mode_console_writer_test NOT OK");
      $finish;
    end
  end

  // A new hold ticket makes the receiver refuse results for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic offer(input logic [CMD_W-1:0] c, input logic [7:0] ch,
                       input logic signed [7:0] x, input logic signed [7:0] y,
                       input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    char_code  <= ch;
    pos_x      <= x;
    pos_y      <= y;
    cell_index <= idx;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_done++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_owed != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] text_byte();
    int pick;
    logic [7:0] ch;
    pick = $urandom_range(99);
    if (pick < 8) begin
      ch = CH_TAB;
    end else if (pick < 14) begin
      ch = CH_NEWLINE;
    end else if (pick < 90) begin
      ch = 8'($urandom_range(8'h7E, CH_SPACE));
    end else begin
      ch = 8'($urandom_range(255));
    end
    return ch;
  endfunction

  task automatic typing_burst(input int n);
    repeat (n) begin
      offer(CMD_PUT, text_byte(), 8'($urandom), 8'($urandom), IDX_W'($urandom));
    end
  endtask

  task automatic random_command();
    int pick;
    logic [7:0] ch;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    x    = 8'($urandom);
    y    = 8'($urandom);
    idx  = IDX_W'($urandom);
    if (pick < 35) begin
      if ($urandom_range(3) == 0) begin
        ch = text_byte();
      end
      offer(CMD_PUT, ch, x, y, idx);
    end else if (pick < 50) begin
      if ($urandom_range(3) != 0) begin
        x = 8'($urandom_range(COLS - 1));
        y = 8'($urandom_range(ROWS - 1));
      end
      offer(CMD_SET, ch, x, y, idx);
    end else if (pick < 65) begin
      if ($urandom_range(9) < 7) begin
        x = 8'(int'($urandom_range(8)) - 4);
        y = 8'(int'($urandom_range(8)) - 4);
      end
      offer(CMD_MOVE, ch, x, y, idx);
    end else if (pick < 93) begin
      if ($urandom_range(4) != 0) begin
        idx = IDX_W'($urandom_range(CELLS - 1));
      end
      offer(CMD_READ, ch, x, y, idx);
    end else if (pick < 95) begin
      offer(CMD_CLEAR, ch, x, y, idx);
    end else begin
      offer(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), ch, x, y, idx);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n);
    int stop_at;
    bit held;
    bit paused;
    write_attr(8'($urandom));
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    stop_at = items_done + n;
    held    = 1'b0;
    paused  = 1'b0;
    while (items_done < stop_at) begin
      if (!held && items_done >= stop_at - n / 2) begin
        held = 1'b1;
        hold_ticket <= hold_ticket + 1;
      end
      if (!paused && items_done >= stop_at - n / 4) begin
        paused = 1'b1;
        wait_idle();
      end
      if ($urandom_range(99) < 8) begin
        typing_burst($urandom_range(30, 3));
      end else begin
        random_command();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    offer(CMD_READ, 8'h00, 8'sd0, 8'sd0, '0);
    offer(CMD_READ, 8'h00, 8'sd0, 8'sd0, IDX_W'(CELLS - 1));
    offer(CMD_READ, 8'h00, 8'sd0, 8'sd0, '1);
    offer(CMD_PUT, 8'hFF, 8'sd0, 8'sd0, '0);
    offer(CMD_PUT, 8'h00, 8'sd0, 8'sd0, '0);
    offer(CMD_PUT, CH_TAB, 8'sd0, 8'sd0, '0);
    offer(CMD_PUT, CH_NEWLINE, 8'sd0, 8'sd0, '0);
    // Cursor to the bottom right corner, then wrap and scroll.
    offer(CMD_SET, 8'h00, 8'sd127, 8'sd127, '0);
    offer(CMD_PUT, 8'h41, 8'sd0, 8'sd0, '0);
    offer(CMD_SET, 8'h00, 8'(COLS - 2), 8'(ROWS - 1), '0);
    offer(CMD_PUT, CH_TAB, 8'sd0, 8'sd0, '0);
    offer(CMD_PUT, CH_NEWLINE, 8'sd0, 8'sd0, '0);
    offer(CMD_SET, 8'h00, 8'sh80, 8'sh80, '0);
    offer(CMD_MOVE, 8'h00, -8'sd1, -8'sd1, '0);
    offer(CMD_MOVE, 8'h00, 8'sd127, 8'sd127, '0);
    offer(CMD_MOVE, 8'h00, 8'sh80, 8'sh80, '0);
    // A tab that lands exactly on the line end wraps without a scroll.
    offer(CMD_SET, 8'h00, 8'(COLS - 4), 8'sd3, '0);
    offer(CMD_PUT, CH_TAB, 8'sd0, 8'sd0, '0);
    offer(CMD_READ, 8'h00, 8'sd0, 8'sd0, IDX_W'(CELLS - COLS));
    offer(CMD_SPARE_LO, 8'hFF, 8'sh80, 8'sd127, '1);
    offer(CMD_SPARE_HI, 8'h00, 8'sd127, 8'sh80, '0);
    offer(CMD_CLEAR, 8'h00, 8'sd0, 8'sd0, '0);
    // The cursor now sits at the start of row 4.
    write_attr(8'h00);
    offer(CMD_PUT, 8'h80, 8'sd0, 8'sd0, '0);
    offer(CMD_READ, 8'h00, 8'sd0, 8'sd0, IDX_W'(4 * COLS));
    write_attr(8'hFF);
    offer(CMD_PUT, 8'h00, 8'sd0, 8'sd0, '0);
    offer(CMD_READ, 8'h00, 8'sd0, 8'sd0, IDX_W'(4 * COLS + 1));

    run_phase(28, 77, PHASE_ITEMS);
    run_phase(77, 28, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);

    wait_idle();
    if (errors == 0) begin
      $display("text_mode_console_writer_test OK");
    end else begin
      $display("text_mode_console_writer_test NOT OK");
    end
    $finish;
  end

endmodule
